// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Full property, clocked on clk_i, off during reset.
`define BOXF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define BOXF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/boxf_pkg.sv =====
// Shared types and constants of the box filter.
package boxf_pkg;

  localparam int CFG_W      = 13;
  localparam int LW_W       = 12;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int MEAN_W     = 16;
  localparam int LANES      = 4;
  localparam int WIN        = 5;
  localparam int FRAME_RST  = 480;

  typedef enum logic [1:0] {
    CFG_WINDOW_MODE  = 2'd0,
    CFG_LINE_WIDTH   = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/core/boxf_pix_if.sv =====
// Pixel input channel: valid/ready with one pixel per beat.
interface boxf_pix_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/core/boxf_mean_if.sv =====
// Result channel: valid/ready with window mean and row/frame end flags.
interface boxf_mean_if
  import boxf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_q8;
  logic              row_end;
  logic              frame_end;

  modport source (output valid, output mean_q8, output row_end, output frame_end, input ready);
  modport sink   (input valid, input mean_q8, input row_end, input frame_end, output ready);
endinterface

// ===== rtl/core/box_filter_mean_3x3_5x5.sv =====
// Streaming 3x3 / 5x5 box filter mean over a padded raster image.
//
// Usage:
//   pix_i takes one pixel per beat in raster order of the padded frame.
//   mean_o gives one Q8.8 window mean per full window, rounded to nearest,
//   with row_end on the last mean of an output row and frame_end on the last
//   mean of the frame. Rows without a full window give no beat.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write window_mode (0), line_width (1)
//   and frame_height (2); write only while the pipe is empty.
// Timing:
//   One pixel per clock sustained while mean_o is not stalled. A mean passes
//   from its accepted pixel through the line store read at the accepting edge,
//   then window shift, column sums, window sum, reciprocal multiply, correction, saturation.
//   Four line store lanes of MAX_WIDTH entries are read once per pixel.
// Reset:
//   Counters, window and config go to their defaults; the line store is not
//   cleared, so the first rows of a frame fill it before any mean is made.
// Stall:
//   While mean_o is stalled, pixels are still taken until the pipe bubbles
//   are used up; then pix_i.ready drops until the output beat moves.
`include "assert_macros.svh"

module box_filter_mean_3x3_5x5
  import boxf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  boxf_pix_if.sink         pix_i,
  boxf_mean_if.source      mean_o
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int CS_W    = PIXEL_BITS + 3;
  localparam int SUM_W   = PIXEL_BITS + 5;
  localparam int NUM_W   = SUM_W + 8;
  localparam int SHIFT   = NUM_W;
  localparam int PROD_W  = NUM_W + SHIFT;
  localparam logic [SHIFT-1:0] RECIP9  = SHIFT'((64'd1 << SHIFT) / 64'd9);
  localparam logic [SHIFT-1:0] RECIP25 = SHIFT'((64'd1 << SHIFT) / 64'd25);
  localparam logic [CW-1:0] LINE_LAST_RST =
    CW'((MAX_WIDTH < 640) ? MAX_WIDTH - 1 : 639);
  localparam logic [ROW_W-1:0] FRAME_LAST_RST = ROW_W'(FRAME_RST - 1);

  // config
  logic             mode_q;
  logic [CW-1:0]    line_last_q;
  logic [ROW_W-1:0] frame_last_q;
  logic [CW-1:0]    line_last_c;
  logic [ROW_W-1:0] frame_last_c;
  logic [LW_W+1:0]  lw_ext;
  logic [LW_W+1:0]  lw_m1;
  logic [FH_W-1:0]  fh;
  logic [FH_W-1:0]  fh_m1;

  always_comb begin
    lw_ext = {2'b00, cfg_wdata_i[LW_W-1:0]};
    lw_m1  = lw_ext - (LW_W+2)'(1);
    fh     = cfg_wdata_i[FH_W-1:0];
    fh_m1  = fh - FH_W'(1);
    if (lw_ext < (LW_W+2)'(5)) begin
      line_last_c = CW'(4);
    end else if (lw_ext > (LW_W+2)'(MAX_WIDTH)) begin
      line_last_c = CW'(MAX_WIDTH - 1);
    end else begin
      line_last_c = lw_m1[CW-1:0];
    end
    if (fh < FH_W'(5)) begin
      frame_last_c = ROW_W'(4);
    end else if (fh > FH_W'(4096)) begin
      frame_last_c = '1;
    end else begin
      frame_last_c = fh_m1[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      line_last_q  <= LINE_LAST_RST;
      frame_last_q <= FRAME_LAST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_MODE:  mode_q       <= cfg_wdata_i[0];
        CFG_LINE_WIDTH:   line_last_q  <= line_last_c;
        CFG_FRAME_HEIGHT: frame_last_q <= frame_last_c;
        default: ;
      endcase
    end
  end

  // pipe control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
  logic take1, take2, take3, take4, take5, take_o;
  logic in_acc;

  assign take_o = !ov_q || mean_o.ready;
  assign take5  = !v5_q || take_o;
  assign take4  = !v4_q || take5;
  assign take3  = !v3_q || take4;
  assign take2  = !v2_q || take3;
  assign take1  = !v1_q || take2;
  assign pix_i.ready = take1;
  assign in_acc = pix_i.valid && take1;

  // position counters
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [2:0]       k_last;
  logic             last_col, last_row, emit_c;

  assign k_last   = mode_q ? 3'd4 : 3'd2;
  assign last_col = col_q >= line_last_q;
  assign last_row = row_q >= frame_last_q;
  assign emit_c   = (col_q >= CW'(k_last)) && (row_q >= ROW_W'(k_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // stage 1: line store lanes, read before write
  logic [PIXEL_BITS-1:0] lane_rd [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (in_acc) begin
        rd_q <= mem[col_q];
        if (row_q[1:0] == 2'(l)) begin
          mem[col_q] <= pix_i.pixel;
        end
      end
    end
    assign lane_rd[l] = rd_q;
  end

  logic [PIXEL_BITS-1:0] px1_q;
  logic [1:0]            lane1_q;
  logic                  emit1_q, rend1_q, fend1_q, k5_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (take1) begin
      v1_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q   <= pix_i.pixel;
      lane1_q <= row_q[1:0];
      emit1_q <= emit_c;
      rend1_q <= last_col;
      fend1_q <= last_col && last_row;
      k5_1_q  <= mode_q;
    end
  end

  // stage 2: window shift
  logic [PIXEL_BITS-1:0] colv [WIN];
  logic [PIXEL_BITS-1:0] win_q [WIN][WIN];
  logic                  emit2_q, rend2_q, fend2_q, k5_2_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      colv[i] = lane_rd[2'(lane1_q + 2'(i))];
    end
    colv[WIN-1] = px1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      win_q <= '{default: '{default: '0}};
    end else if (take2) begin
      v2_q <= v1_q;
      if (v1_q) begin
        for (int r = 0; r < WIN; r++) begin
          for (int c = 0; c < WIN - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
          win_q[r][WIN-1] <= colv[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take2 && v1_q) begin
      emit2_q <= emit1_q;
      rend2_q <= rend1_q;
      fend2_q <= fend1_q;
      k5_2_q  <= k5_1_q;
    end
  end

  // stage 3: column sums
  logic [CS_W-1:0] cs_c [WIN];
  logic [CS_W-1:0] cs_q [WIN];
  logic            rend3_q, fend3_q, k5_3_q;

  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      cs_c[c] = CS_W'(win_q[2][c]) + CS_W'(win_q[3][c]) + CS_W'(win_q[4][c]);
      if (k5_2_q) begin
        cs_c[c] = cs_c[c] + CS_W'(win_q[0][c]) + CS_W'(win_q[1][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (take3) begin
      v3_q <= v2_q && emit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take3 && v2_q) begin
      cs_q    <= cs_c;
      rend3_q <= rend2_q;
      fend3_q <= fend2_q;
      k5_3_q  <= k5_2_q;
    end
  end

  // stage 4: window sum, scaled and biased for rounding
  logic [SUM_W-1:0] sum_c;
  logic [NUM_W-1:0] num_c;
  logic [NUM_W-1:0] n4_q;
  logic             rend4_q, fend4_q, k5_4_q;

  always_comb begin
    sum_c = SUM_W'(cs_q[2]) + SUM_W'(cs_q[3]) + SUM_W'(cs_q[4]);
    if (k5_3_q) begin
      sum_c = sum_c + SUM_W'(cs_q[0]) + SUM_W'(cs_q[1]);
    end
    num_c = {sum_c, 8'd0} + (k5_3_q ? NUM_W'(12) : NUM_W'(4));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (take4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take4 && v3_q) begin
      n4_q    <= num_c;
      rend4_q <= rend3_q;
      fend4_q <= fend3_q;
      k5_4_q  <= k5_3_q;
    end
  end

  // stage 5: reciprocal multiply, quotient may be one low
  logic [SHIFT-1:0]  recip;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  q0_q, n5_q;
  logic              rend5_q, fend5_q, k5_5_q;

  assign recip = k5_4_q ? RECIP25 : RECIP9;
  assign prod  = PROD_W'(n4_q) * PROD_W'(recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (take5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take5 && v4_q) begin
      q0_q    <= prod[PROD_W-1:SHIFT];
      n5_q    <= n4_q;
      rend5_q <= rend4_q;
      fend5_q <= fend4_q;
      k5_5_q  <= k5_4_q;
    end
  end

  // stage 6: remainder correction and saturation
  logic [NUM_W-1:0]  qd, rem, d_val, q_fix;
  logic [MEAN_W-1:0] mean_c;
  logic [MEAN_W-1:0] mean_q;
  logic              rend_q, fend_q;

  always_comb begin
    d_val = k5_5_q ? NUM_W'(25) : NUM_W'(9);
    qd    = (q0_q << 3) + q0_q;
    if (k5_5_q) begin
      qd = qd + (q0_q << 4);
    end
    rem   = n5_q - qd;
    q_fix = (rem >= d_val) ? q0_q + NUM_W'(1) : q0_q;
    if (q_fix > NUM_W'({MEAN_W{1'b1}})) begin
      mean_c = '1;
    end else begin
      mean_c = MEAN_W'(q_fix);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (take_o) begin
      ov_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && v5_q) begin
      mean_q <= mean_c;
      rend_q <= rend5_q;
      fend_q <= fend5_q;
    end
  end

  assign mean_o.valid     = ov_q;
  assign mean_o.mean_q8   = mean_q;
  assign mean_o.row_end   = rend_q;
  assign mean_o.frame_end = fend_q;

  `BOXF_ASSERT(a_accept_fills_s1, in_acc |=> v1_q, "accepted beat did not reach stage 1")
  `BOXF_ASSERT_IMPL(a_rem_range, v5_q, rem < (d_val << 1), "reciprocal quotient off by more than one")
  `BOXF_ASSERT_IMPL(a_frame_on_row, ov_q && fend_q, rend_q, "frame end without row end")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Box filter mean testbench: stimulus table, then random frames checked against a predictor.
module testbench;
  import boxf_pkg::*;

  localparam int MAXW   = 2048;
  localparam int MAXH   = 4096;
  localparam int SETTLE = 12;

  typedef struct {
    logic [MEAN_W-1:0] mean_q8;
    logic              row_end;
    logic              frame_end;
  } mean_beat_t;

  typedef enum int {SK_CFG, SK_FILL, SK_RAND} stim_kind_e;

  typedef struct {
    stim_kind_e        kind;
    cfg_idx_e          idx;
    int                value;
    int                count;
    bit                typed;
    logic [MEAN_W-1:0] tmean;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  boxf_pix_if #(.PIXEL_BITS(8)) pix_if ();
  boxf_mean_if                  mean_if ();

  box_filter_mean_3x3_5x5 #(
    .MAX_WIDTH (MAXW),
    .PIXEL_BITS(8)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix_if),
    .mean_o     (mean_if)
  );

  // predictor state
  bit              win_mode_q;
  logic [LW_W-1:0] line_w_q;
  logic [FH_W-1:0] frame_h_q;
  logic [7:0]      lstore [0:4*MAXW-1];
  logic [7:0]      win_q [5][5];
  int              col_q;
  int              row_q;

  mean_beat_t mean_expq [$];
  int         err_cnt;
  bit         tx_idle;
  bit         hold_req;
  int         rand_items;

  stim_row_t plan [23] = '{
    '{SK_FILL, CFG_WINDOW_MODE,  255,  4,    1'b1, 16'd65280},
    '{SK_CFG,  CFG_FRAME_HEIGHT, 5,    0,    1'b0, 16'd0},
    '{SK_CFG,  CFG_LINE_WIDTH,   5,    0,    1'b0, 16'd0},
    '{SK_FILL, CFG_WINDOW_MODE,  255,  21,   1'b1, 16'd65280},
    '{SK_FILL, CFG_WINDOW_MODE,  0,    25,   1'b1, 16'd0},
    '{SK_FILL, CFG_WINDOW_MODE,  255,  25,   1'b1, 16'd65280},
    '{SK_CFG,  CFG_WINDOW_MODE,  1,    0,    1'b0, 16'd0},
    '{SK_FILL, CFG_WINDOW_MODE,  0,    25,   1'b1, 16'd0},
    '{SK_FILL, CFG_WINDOW_MODE,  255,  25,   1'b1, 16'd65280},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    25,   1'b0, 16'd0},
    '{SK_CFG,  CFG_LINE_WIDTH,   0,    0,    1'b0, 16'd0},
    '{SK_CFG,  CFG_FRAME_HEIGHT, 0,    0,    1'b0, 16'd0},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    25,   1'b0, 16'd0},
    '{SK_CFG,  CFG_WINDOW_MODE,  0,    0,    1'b0, 16'd0},
    '{SK_CFG,  CFG_LINE_WIDTH,   9,    0,    1'b0, 16'd0},
    '{SK_CFG,  CFG_FRAME_HEIGHT, 9,    0,    1'b0, 16'd0},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    25,   1'b0, 16'd0},
    '{SK_CFG,  CFG_LINE_WIDTH,   6,    0,    1'b0, 16'd0},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    25,   1'b0, 16'd0},
    '{SK_CFG,  CFG_FRAME_HEIGHT, 5,    0,    1'b0, 16'd0},
    '{SK_CFG,  CFG_WINDOW_MODE,  1,    0,    1'b0, 16'd0},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    6,    1'b0, 16'd0},
    '{SK_RAND, CFG_WINDOW_MODE,  0,    30,   1'b0, 16'd0}
  };

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [7:0] rand_pix();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit at_frame_start();
    return col_q == 0 && row_q == 0;
  endfunction

  task automatic filter_step(input logic [7:0] p, input bit typed,
                             input logic [MEAN_W-1:0] tmean);
    int w, h, k, c, r, sum, mean;
    bit last_col, last_row;
    logic [7:0] colv [5];
    mean_beat_t b;
    w = clamp_int(int'(line_w_q), 5, MAXW);
    h = clamp_int(int'(frame_h_q), 5, MAXH);
    k = win_mode_q ? 5 : 3;
    c = col_q % MAXW;
    r = row_q % MAXH;
    for (int d = 1; d <= 4; d++) colv[4-d] = lstore[((r - d) & 3) * MAXW + c];
    colv[4] = p;
    lstore[(r & 3) * MAXW + c] = p;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win_q[i][j] = win_q[i][j+1];
      win_q[i][4] = colv[i];
    end
    last_col = c >= w - 1;
    last_row = r >= h - 1;
    if (c >= k - 1 && r >= k - 1) begin
      sum = 0;
      for (int i = 5 - k; i < 5; i++)
        for (int j = 5 - k; j < 5; j++) sum += int'(win_q[i][j]);
      mean = (sum * 256 + (k * k) / 2) / (k * k);
      if (mean > 65535) mean = 65535;
      b.mean_q8   = typed ? tmean : MEAN_W'(mean);
      b.row_end   = last_col;
      b.frame_end = last_col && last_row;
      mean_expq.push_back(b);
    end
    if (last_col) begin
      col_q = 0;
      row_q = last_row ? 0 : r + 1;
    end else begin
      col_q = c + 1;
      row_q = r;
    end
  endtask

  task automatic send_pixel(input logic [7:0] p, input bit typed,
                            input logic [MEAN_W-1:0] tmean);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    do @(posedge clk_i); while (!pix_if.ready);
    filter_step(p, typed, tmean);
  endtask

  // stop offering and let the pipe run dry
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (mean_expq.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_WINDOW_MODE:  win_mode_q = val[0];
      CFG_LINE_WIDTH:   line_w_q   = val[LW_W-1:0];
      CFG_FRAME_HEIGHT: frame_h_q  = val[FH_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_all(input int mode, input int width, input int height);
    cfg_write(CFG_WINDOW_MODE, mode);
    cfg_write(CFG_LINE_WIDTH, width);
    cfg_write(CFG_FRAME_HEIGHT, height);
  endtask

  // width may only shrink inside a frame
  task automatic mid_frame_change();
    int cw;
    settle();
    cw = clamp_int(int'(line_w_q), 5, MAXW);
    cfg_all($urandom_range(0, 1), $urandom_range(0, cw), $urandom_range(0, 12));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(50_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // result sink: random back-pressure plus one long hold-off on request
  initial begin : rx_proc
    int stall_left;
    int cyc;
    bit rx_idle;
    stall_left = 0;
    cyc = 0;
    rx_idle = 1'b1;
    mean_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 256 == 0) rx_idle = $urandom_range(0, 3) != 0;
      if (!rst_ni) begin
        mean_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        mean_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        mean_if.ready <= 1'b0;
      end else begin
        mean_if.ready <= 1'b1;
        if (rx_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : chk
    mean_beat_t want;
    if (rst_ni && mean_if.valid && mean_if.ready) begin
      if (mean_expq.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected mean beat: mean_q8 %0d row_end %0b frame_end %0b",
                 $time, mean_if.mean_q8, mean_if.row_end, mean_if.frame_end);
      end else begin
        want = mean_expq.pop_front();
        if (mean_if.mean_q8 !== want.mean_q8) begin
          err_cnt++;
          $display("%0t mean_q8 mismatch: expected %0d, got %0d",
                   $time, want.mean_q8, mean_if.mean_q8);
        end
        if (mean_if.row_end !== want.row_end) begin
          err_cnt++;
          $display("%0t row_end mismatch: expected %0b, got %0b",
                   $time, want.row_end, mean_if.row_end);
        end
        if (mean_if.frame_end !== want.frame_end) begin
          err_cnt++;
          $display("%0t frame_end mismatch: expected %0b, got %0b",
                   $time, want.frame_end, mean_if.frame_end);
        end
      end
    end
  end

  initial begin : stim_proc
    int frames;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_WINDOW_MODE;
    cfg_wdata_i  = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    err_cnt      = 0;
    tx_idle      = 1'b1;
    hold_req     = 1'b0;
    rand_items   = 0;
    win_mode_q   = 1'b0;
    line_w_q     = LW_W'(640);
    frame_h_q    = FH_W'(FRAME_RST);
    col_q        = 0;
    row_q        = 0;
    for (int i = 0; i < 4 * MAXW; i++) lstore[i] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) win_q[i][j] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; first row runs on reset settings
    foreach (plan[i]) begin
      case (plan[i].kind)
        SK_CFG: begin
          settle();
          cfg_write(plan[i].idx, plan[i].value);
        end
        SK_FILL: repeat (plan[i].count)
          send_pixel(plan[i].value[7:0], plan[i].typed, plan[i].tmean);
        default: repeat (plan[i].count) send_pixel(rand_pix(), 1'b0, '0);
      endcase
    end

    // widest rows, then shrink inside the frame
    settle();
    cfg_all(0, 4095, 5);
    repeat (8) send_pixel(rand_pix(), 1'b0, '0);
    settle();
    cfg_write(CFG_LINE_WIDTH, 5);
    repeat (21) send_pixel(rand_pix(), 1'b0, '0);

    // tallest frame, then cut short inside the frame
    settle();
    cfg_all(1, 5, 8191);
    repeat (30) send_pixel(rand_pix(), 1'b0, '0);
    settle();
    cfg_write(CFG_FRAME_HEIGHT, 5);
    repeat (5) send_pixel(rand_pix(), 1'b0, '0);

    frames = 0;
    while (rand_items < 100) begin
      settle();
      if (frames == 0) begin
        cfg_all(0, 12, 8);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end else begin
        cfg_all($urandom_range(0, 1),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 8));
        tx_idle = $urandom_range(0, 3) != 0;
      end
      do begin
        send_pixel(rand_pix(), 1'b0, '0);
        rand_items++;
        if (!at_frame_start() && frames != 0 && $urandom_range(0, 39) == 0)
          mid_frame_change();
      end while (!at_frame_start());
      frames++;
    end

    settle();
    if (err_cnt == 0 && mean_expq.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
